>>> rtl/core/gsom_pkg.sv
`timescale 1ns / 1ps
// gsom_pkg: shared types, codes and defaults for the grid slot occupancy map
// used by gsom_ctrl, gsom_datapath and grid_slot_occupancy_map_top
package gsom_pkg;

  // default grid limits and count width
  localparam int DefMaxX       = 64;
  localparam int DefMaxY       = 16;
  localparam int DefMaxZ       = 8;
  localparam int DefCountWidth = 32;

  // configuration register widths and reset values
  localparam int XSizeW = 7;
  localparam int YSizeW = 5;
  localparam int ZSizeW = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;
  localparam logic [XSizeW-1:0] XSizeRst = 7'd64;
  localparam logic [YSizeW-1:0] YSizeRst = 5'd16;
  localparam logic [ZSizeW-1:0] ZSizeRst = 4'd8;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_GRID_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_GRID_Z = 2'd2;

  // input fields
  localparam int ModeW   = 2;
  localparam int CoordXW = 6;
  localparam int CoordYW = 4;
  localparam int CoordZW = 3;
  localparam int InDataW = 16;

  // output fields
  localparam int UseCountW = 32;
  localparam int StatusW   = 2;
  localparam int OutDataW  = 40;

  // request modes
  localparam logic [ModeW-1:0] MODE_ALLOC = 2'd0;
  localparam logic [ModeW-1:0] MODE_FREE  = 2'd1;
  localparam logic [ModeW-1:0] MODE_QUERY = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_DOUBLE    = 2'd1;
  localparam logic [StatusW-1:0] STAT_NOT_ALLOC = 2'd2;
  localparam logic [StatusW-1:0] STAT_RANGE     = 2'd3;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_PROD   = 6'b000100,
    ST_IDX    = 6'b001000,
    ST_READ   = 6'b010000,
    ST_UPDATE = 6'b100000
  } ctrl_state_e;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic clr_step;
    logic calc_prod;
    logic calc_idx;
    logic mem_read;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/core/grid_slot_occupancy_map_top.sv
`timescale 1ns / 1ps
// grid_slot_occupancy_map_top: occupancy bitmap with use counters over a
// 3-d grid of cells; instantiates gsom_ctrl and gsom_datapath, uses gsom_pkg
//
// usage
//   s_axis carries one request per beat (allocate, free or query a cell);
//   m_axis returns exactly one result beat per request, in order
//   cfg channel writes the grid sizes: index 0 x, 1 y, 2 z; other indexes
//   are accepted and dropped; write only while no request is in flight
//   cell index is x + y*xs + z*xs*ys with sizes capped at MAX_X/Y/Z and at 127/31/15
// request steps
//   each request passes accept, two index steps (multiplier products,
//   then the sum), registered memory read, then update and result load
//   only one request is in flight at a time
// reset
//   after reset a clearing pass writes every cell to zero, one cell per
//   cycle (MAX_X*MAX_Y*MAX_Z cells, 8192 by default); s_axis_tready is
//   low meanwhile, the cfg channel is always ready
// stall
//   the result waits in an output register; a new request is taken and
//   processed up to the update step, which holds until the result is taken
module grid_slot_occupancy_map_top #(
  parameter int MAX_X       = gsom_pkg::DefMaxX,
  parameter int MAX_Y       = gsom_pkg::DefMaxY,
  parameter int MAX_Z       = gsom_pkg::DefMaxZ,
  parameter int COUNT_WIDTH = gsom_pkg::DefCountWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // mode[1:0], coord_x[7:2], coord_y[11:8], coord_z[14:12], zero[15]
  input  logic [gsom_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // occupied[0], use_count[32:1], status[34:33], zero[39:35]
  output logic [gsom_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gsom_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gsom_pkg::CfgDataW-1:0]   cfg_data_i
);
  import gsom_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  gsom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gsom_datapath #(
    .MAX_X       (MAX_X),
    .MAX_Y       (MAX_Y),
    .MAX_Z       (MAX_Z),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  assign s_axis_tready = cmd.in_ready;
  assign cfg_ready_o   = 1'b1;

endmodule

>>> rtl/core/gsom_ctrl.sv
`timescale 1ns / 1ps
// gsom_ctrl: sequencer for the clearing pass and the per-request
// read-modify-write steps; depends on gsom_pkg
module gsom_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  gsom_pkg::ctrl_sts_t   sts_i,
  output gsom_pkg::ctrl_cmd_t   cmd_o
);
  import gsom_pkg::*;

  ctrl_state_e state_q, state_d;
  ctrl_cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.calc_prod = 1'b1;
        state_d       = ST_IDX;
      end
      ST_IDX: begin
        cmd.calc_idx = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.out_free) begin
          cmd.update = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

  a_update_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |-> sts_i.out_free)
    else $error("result written while output slot busy");

  a_clear_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) && sts_i.clr_done |=> (state_q == ST_IDLE))
    else $error("clearing pass did not end in idle");

  a_load_then_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_in |=> (state_q == ST_PROD))
    else $error("accepted beat not followed by index step");

  a_update_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |=> (state_q == ST_IDLE) && !cmd.clr_step)
    else $error("update not followed by idle");

endmodule

>>> rtl/core/gsom_datapath.sv
`timescale 1ns / 1ps
// gsom_datapath: size registers, index arithmetic, cell memory and
// output register; depends on gsom_pkg, driven by gsom_ctrl
module gsom_datapath #(
  parameter int MAX_X       = gsom_pkg::DefMaxX,
  parameter int MAX_Y       = gsom_pkg::DefMaxY,
  parameter int MAX_Z       = gsom_pkg::DefMaxZ,
  parameter int COUNT_WIDTH = gsom_pkg::DefCountWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gsom_pkg::ctrl_cmd_t             cmd_i,
  output gsom_pkg::ctrl_sts_t             sts_o,
  input  logic                            cfg_valid_i,
  input  logic [gsom_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gsom_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [gsom_pkg::InDataW-1:0]    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gsom_pkg::OutDataW-1:0]   out_data_o
);
  import gsom_pkg::*;

  localparam int Cells   = MAX_X * MAX_Y * MAX_Z;
  localparam int IdxW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int SumW    = 16;
  localparam int ExtW    = (IdxW > SumW) ? IdxW : SumW;
  localparam int CntExtW = (COUNT_WIDTH > 33) ? COUNT_WIDTH : 33;
  localparam int WordW   = COUNT_WIDTH + 1;
  localparam int XCap    = (MAX_X < 127) ? MAX_X : 127;
  localparam int YCap    = (MAX_Y < 31) ? MAX_Y : 31;
  localparam int ZCap    = (MAX_Z < 15) ? MAX_Z : 15;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Cells - 1);

  logic [XSizeW-1:0] xs_reg_q, xs;
  logic [YSizeW-1:0] ys_reg_q, ys;
  logic [ZSizeW-1:0] zs_reg_q, zs;

  logic [ModeW-1:0]   mode_q;
  logic [CoordXW-1:0] x_q;
  logic [CoordYW-1:0] y_q;
  logic [CoordZW-1:0] z_q;

  logic [10:0]     yxs_q;
  logic [11:0]     xsys_q;
  logic            in_range_q;
  logic [SumW-1:0] idx_sum;
  logic [ExtW-1:0] idx_ext;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] clr_addr_q;

  logic [WordW-1:0] mem [Cells];
  logic [WordW-1:0] rd_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [WordW-1:0] mem_wdata;

  logic                   occ_rd, occ_new;
  logic [COUNT_WIDTH-1:0] cnt_rd, cnt_new, cnt_inc;
  logic [StatusW-1:0]     status;
  logic [CntExtW-1:0]     cnt_ext;
  logic [UseCountW-1:0]   use32;

  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_reg_q <= XSizeRst;
      ys_reg_q <= YSizeRst;
      zs_reg_q <= ZSizeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRID_X: xs_reg_q <= cfg_data_i[XSizeW-1:0];
        REG_GRID_Y: ys_reg_q <= cfg_data_i[YSizeW-1:0];
        REG_GRID_Z: zs_reg_q <= cfg_data_i[ZSizeW-1:0];
        default: ;
      endcase
    end
  end

  assign xs = (xs_reg_q > XSizeW'(XCap)) ? XSizeW'(XCap) : xs_reg_q;
  assign ys = (ys_reg_q > YSizeW'(YCap)) ? YSizeW'(YCap) : ys_reg_q;
  assign zs = (zs_reg_q > ZSizeW'(ZCap)) ? ZSizeW'(ZCap) : zs_reg_q;

  // request capture and index arithmetic
  assign idx_sum = {10'd0, x_q} + {5'd0, yxs_q} + ({13'd0, z_q} * {4'd0, xsys_q});
  assign idx_ext = ExtW'(idx_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= in_data_i[1:0];
      x_q    <= in_data_i[7:2];
      y_q    <= in_data_i[11:8];
      z_q    <= in_data_i[14:12];
    end
    if (cmd_i.calc_prod) begin
      yxs_q      <= {7'd0, y_q} * {4'd0, xs};
      xsys_q     <= {5'd0, xs} * {7'd0, ys};
      in_range_q <= ({1'b0, x_q} < xs) && ({1'b0, y_q} < ys) && ({1'b0, z_q} < zs);
    end
    if (cmd_i.calc_idx) begin
      idx_q <= idx_ext[IdxW-1:0];
    end
  end

  // clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step && (clr_addr_q != LastIdx)) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // cell memory, one word per cell: {occupied, count}
  assign mem_we    = cmd_i.clr_step || (cmd_i.update && in_range_q);
  assign mem_waddr = cmd_i.clr_step ? clr_addr_q : idx_q;
  assign mem_wdata = cmd_i.clr_step ? '0 : {occ_new, cnt_new};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.mem_read) rd_q <= mem[idx_q];
  end

  // update of the read word
  assign occ_rd  = rd_q[COUNT_WIDTH];
  assign cnt_rd  = rd_q[COUNT_WIDTH-1:0];
  assign cnt_inc = (&cnt_rd) ? cnt_rd : cnt_rd + COUNT_WIDTH'(1);

  always_comb begin
    occ_new = occ_rd;
    cnt_new = cnt_rd;
    status  = STAT_OK;
    case (mode_q)
      MODE_ALLOC: begin
        if (occ_rd) begin
          status = STAT_DOUBLE;
        end else begin
          occ_new = 1'b1;
          cnt_new = cnt_inc;
        end
      end
      MODE_FREE: begin
        if (!occ_rd) status = STAT_NOT_ALLOC;
        else occ_new = 1'b0;
      end
      default: ;
    endcase
  end

  assign cnt_ext = CntExtW'(cnt_new);
  assign use32   = (|cnt_ext[CntExtW-1:UseCountW]) ? '1 : cnt_ext[UseCountW-1:0];

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (in_range_q) out_data_q <= {5'd0, status, use32, occ_new};
      else out_data_q <= {5'd0, STAT_RANGE, 32'd0, 1'b0};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign sts_o.clr_done  = (clr_addr_q == LastIdx);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule
